// ===== design/s256_pkg.sv =====
// shared types and constants for the sha-256 byte stream hasher
`timescale 1ns / 1ps

package s256_pkg;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } t_state;

    // source of the byte pushed into the block buffer
    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } t_src;

    // controller to datapath
    typedef struct packed {
        logic push;
        t_src src;
        logic init_work;
        logic round_step;
        logic fold;
        logic out_next;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
        logic       out_last;
    } t_sts;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam int         PAD_LIMIT = 56;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ===== design/s256_ctrl.sv =====
// controller state machine: byte intake, padding, rounds and digest output
`timescale 1ns / 1ps

module s256_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_byte_present,
    input  logic           i_end_of_message,
    input  logic           i_stall,
    input  s256_pkg::t_sts i_sts,
    output logic           o_stall,
    output logic           o_valid,
    output s256_pkg::t_cmd o_cmd
);

    s256_pkg::t_state r_state, n_state;
    logic r_final, n_final;   // finalization in progress
    logic r_mark, n_mark;     // 0x80 marker already pushed
    logic r_extra, n_extra;   // length goes into a further block

    logic w_fill_last;
    logic w_len_zone;

    assign w_fill_last = (i_sts.fill == 6'd63);
    assign w_len_zone  = (i_sts.fill >= 6'(s256_pkg::PAD_LIMIT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= s256_pkg::ST_IDLE;
            r_final <= 1'b0;
            r_mark  <= 1'b0;
            r_extra <= 1'b0;
        end else begin
            r_state <= n_state;
            r_final <= n_final;
            r_mark  <= n_mark;
            r_extra <= n_extra;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_final = r_final;
        n_mark  = r_mark;
        n_extra = r_extra;
        unique case (r_state)
            s256_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_byte_present && w_fill_last) begin
                        n_state = s256_pkg::ST_COMP;
                        n_final = i_end_of_message;
                        n_mark  = 1'b0;
                        n_extra = 1'b0;
                    end else if (i_end_of_message) begin
                        n_state = s256_pkg::ST_PAD;
                        n_final = 1'b1;
                        n_mark  = 1'b0;
                        n_extra = 1'b0;
                    end
                end
            end
            s256_pkg::ST_PAD: begin
                n_mark = 1'b1;
                if (!r_mark) begin
                    n_extra = w_len_zone;
                end
                if (w_fill_last) begin
                    n_state = s256_pkg::ST_COMP;
                end
            end
            s256_pkg::ST_COMP: begin
                if (i_sts.round_last) begin
                    n_state = s256_pkg::ST_FOLD;
                end
            end
            s256_pkg::ST_FOLD: begin
                priority if (!r_final) begin
                    n_state = s256_pkg::ST_IDLE;
                end else if (!r_mark) begin
                    n_state = s256_pkg::ST_PAD;
                end else if (r_extra) begin
                    n_state = s256_pkg::ST_PAD;
                    n_extra = 1'b0;
                end else begin
                    n_state = s256_pkg::ST_OUT;
                end
            end
            s256_pkg::ST_OUT: begin
                if (!i_stall && i_sts.out_last) begin
                    n_state = s256_pkg::ST_IDLE;
                    n_final = 1'b0;
                end
            end
            default: begin
                n_state = s256_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.src        = s256_pkg::SRC_DATA;
        o_stall          = 1'b1;
        o_valid          = 1'b0;
        unique case (r_state)
            s256_pkg::ST_IDLE: begin
                o_stall        = 1'b0;
                o_cmd.push     = i_valid && i_byte_present;
                o_cmd.init_work = i_valid && i_byte_present && w_fill_last;
            end
            s256_pkg::ST_PAD: begin
                o_cmd.push      = 1'b1;
                o_cmd.init_work = w_fill_last;
                priority if (!r_mark) begin
                    o_cmd.src = s256_pkg::SRC_MARK;
                end else if (!w_len_zone || r_extra) begin
                    o_cmd.src = s256_pkg::SRC_ZERO;
                end else begin
                    o_cmd.src = s256_pkg::SRC_LEN;
                end
            end
            s256_pkg::ST_COMP: begin
                o_cmd.round_step = 1'b1;
            end
            s256_pkg::ST_FOLD: begin
                o_cmd.fold = 1'b1;
            end
            s256_pkg::ST_OUT: begin
                o_valid        = 1'b1;
                o_cmd.out_next = !i_stall;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== design/s256_dp.sv =====
// datapath: block buffer and schedule, round logic, chaining words, counters
`timescale 1ns / 1ps

module s256_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  s256_pkg::t_cmd i_cmd,
    input  logic [7:0]     i_data_byte,
    output s256_pkg::t_sts o_sts,
    output logic [31:0]    o_digest_word,
    output logic [2:0]     o_word_position,
    output logic           o_final_word
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // byte 0 of the block ends up in the top byte, the schedule shifts the same way
    logic [511:0] r_blk;
    logic [31:0]  r_work [8];
    logic [31:0]  r_chain [8];
    logic [60:0]  r_count;
    logic [5:0]   r_fill;
    logic [5:0]   r_round;
    logic [2:0]   r_pos;

    logic [63:0] w_len_sh;
    logic [7:0]  w_byte;
    logic [31:0] w_w0, w_w1, w_w9, w_w14, w_new;
    logic [31:0] w_s0, w_s1, w_ch, w_maj, w_t1, w_t2;

    // length byte for fill 56..63 picks bytes of the bit count msb first
    assign w_len_sh = {r_count, 3'b000} << {r_fill[2:0], 3'b000};

    always_comb begin
        unique case (i_cmd.src)
            s256_pkg::SRC_DATA: w_byte = i_data_byte;
            s256_pkg::SRC_MARK: w_byte = s256_pkg::PAD_MARK;
            s256_pkg::SRC_ZERO: w_byte = 8'h00;
            s256_pkg::SRC_LEN:  w_byte = w_len_sh[63:56];
            default:            w_byte = 8'h00;
        endcase
    end

    // message schedule on a 16-word shift window
    assign w_w0  = r_blk[511:480];
    assign w_w1  = r_blk[479:448];
    assign w_w9  = r_blk[223:192];
    assign w_w14 = r_blk[63:32];
    assign w_new = (rotr(w_w14, 17) ^ rotr(w_w14, 19) ^ (w_w14 >> 10)) + w_w9
                 + (rotr(w_w1, 7) ^ rotr(w_w1, 18) ^ (w_w1 >> 3)) + w_w0;

    // one compression round
    assign w_s1  = rotr(r_work[4], 6) ^ rotr(r_work[4], 11) ^ rotr(r_work[4], 25);
    assign w_ch  = (r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]);
    assign w_t1  = r_work[7] + w_s1 + w_ch + s256_pkg::ROUND_K[r_round] + w_w0;
    assign w_s0  = rotr(r_work[0], 2) ^ rotr(r_work[0], 13) ^ rotr(r_work[0], 22);
    assign w_maj = (r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2])
                 ^ (r_work[1] & r_work[2]);
    assign w_t2  = w_s0 + w_maj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_blk <= {r_blk[503:0], w_byte};
        end else if (i_cmd.round_step) begin
            r_blk <= {r_blk[479:0], w_new};
        end
        if (i_cmd.init_work) begin
            for (int i = 0; i < 8; i++) begin
                r_work[i] <= r_chain[i];
            end
        end else if (i_cmd.round_step) begin
            r_work[7] <= r_work[6];
            r_work[6] <= r_work[5];
            r_work[5] <= r_work[4];
            r_work[4] <= r_work[3] + w_t1;
            r_work[3] <= r_work[2];
            r_work[2] <= r_work[1];
            r_work[1] <= r_work[0];
            r_work[0] <= w_t1 + w_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= s256_pkg::INIT_H[i];
            end
            r_count <= '0;
            r_fill  <= '0;
            r_round <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cmd.push) begin
                r_fill <= r_fill + 6'd1;
                if (i_cmd.src == s256_pkg::SRC_DATA) begin
                    r_count <= r_count + 61'd1;
                end
            end
            if (i_cmd.init_work) begin
                r_round <= '0;
            end else if (i_cmd.round_step) begin
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_work[i];
                end
            end
            if (i_cmd.out_next) begin
                r_pos <= r_pos + 3'd1;
                if (r_pos == 3'd7) begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= s256_pkg::INIT_H[i];
                    end
                    r_count <= '0;
                end
            end
        end
    end

    assign o_sts.fill       = r_fill;
    assign o_sts.round_last = (r_round == 6'd63);
    assign o_sts.out_last   = (r_pos == 3'd7);

    assign o_digest_word   = r_chain[r_pos];
    assign o_word_position = r_pos;
    assign o_final_word    = (r_pos == 3'd7);

endmodule

// ===== design/sha256_byte_stream_hasher.sv =====
// top level of the streaming sha-256 hasher, one message byte per request
// usage:
//   input channel (i_valid / o_stall) carries one request: i_data_byte, valid
//   when i_byte_present is set, and i_end_of_message to close the message
//   output channel (o_valid / i_stall) carries the eight digest words, word 0
//   (most significant) first, o_final_word set on word 7
// timing:
//   a byte that does not complete a 64-byte block is taken without a stall
//   a byte that completes a block holds o_stall through 64 rounds of the
//   single shared round unit and a fold of the result; the working words
//   load on the accepting edge itself
//   end of message: padding bytes enter one per cycle (64 minus pending bytes),
//   then a compression, plus another 64 padding bytes and a compression
//   when 56 or more bytes were pending, then 8 digest requests at one per
//   cycle while i_stall is low; a closing byte that fills the block first runs
//   its own compression; o_stall stays high from the closing request until the
//   last digest word has been taken
// reset: synchronous, active low; chaining words go to the sha-256 initial
//   values and the byte counts clear, no clearing pass is needed
// a high i_stall simply holds the current digest word on the outputs
`timescale 1ns / 1ps

module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input requests
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    // digest requests
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_position,
    output logic        o_final_word
);

    s256_pkg::t_cmd w_cmd;   // commands to the datapath
    s256_pkg::t_sts w_sts;   // fill level, round and output position status

    // sequencing: intake, padding, 64 rounds, fold, digest output
    s256_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .i_stall          (i_stall),
        .i_sts            (w_sts),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .o_cmd            (w_cmd)
    );

    // block buffer doubling as schedule window, round unit and digest registers
    s256_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_data_byte     (i_data_byte),
        .o_sts           (w_sts),
        .o_digest_word   (o_digest_word),
        .o_word_position (o_word_position),
        .o_final_word    (o_final_word)
    );

endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for the streaming sha-256 byte hasher
`timescale 1ns / 1ps

module tb_top;

    // run limits: the slowest legal run stays far below the cycle limit
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 400;   // two compressions plus padding, with margin
    localparam int RANDOM_ITEMS = 60;

    // sha-256 initial hash values and round constants
    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // one expected digest request
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  pos;
        logic        last;
    } t_digest_req;

    // clock, reset and dut ports; the inputs driven here are known from time zero
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte      = 8'h00;
    logic        i_byte_present   = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_position;
    logic        o_final_word;

    // predictor state: chaining words, pending block, byte count
    logic [31:0] hash_state [8];
    logic [7:0]  blk_bytes [64];
    int unsigned blk_fill;
    logic [60:0] msg_bytes;

    // digest words still owed by the dut, oldest first
    t_digest_req digest_q [$];

    int err_count   = 0;
    int cycle_count = 0;
    int msg_items   = 0;   // requests carrying a byte or an end flag
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_left  = 0;

    always #5 i_clk = ~i_clk;

    sha256_byte_stream_hasher i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_digest_word    (o_digest_word),
        .o_word_position  (o_word_position),
        .o_final_word     (o_final_word)
    );

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // back to a fresh message
    function automatic void restart_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = SHA_IV[i];
        blk_fill  = 0;
        msg_bytes = '0;
    endfunction

    // 64 rounds over the pending block, folded into the chaining words
    function automatic void fold_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, w15, w2, sig0, sig1, s0, s1, ch, maj, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                // rolling 16-word message schedule
                w15  = w[(t - 15) & 15];
                w2   = w[(t - 2) & 15];
                sig0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
                sig1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
                wt   = w[t & 15] + sig0 + w[(t - 7) & 15] + sig1;
                w[t & 15] = wt;
            end
            s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1  = v[7] + s1 + ch + SHA_K[t] + wt;
            s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2  = s0 + maj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
    endfunction

    // absorb one accepted request, queue the digest on end of message
    function automatic void absorb_request(logic [7:0] data, logic present, logic eom);
        logic [63:0] bit_len;
        t_digest_req dw;
        if (present) begin
            blk_bytes[blk_fill] = data;
            blk_fill++;
            msg_bytes = msg_bytes + 1'b1;   // wraps at 2^61
            if (blk_fill == 64) begin
                fold_block();
                blk_fill = 0;
            end
        end
        if (!eom) return;

        bit_len = {msg_bytes, 3'b000};
        blk_bytes[blk_fill] = 8'h80;
        blk_fill++;
        // no room left for the length: pad out and compress an extra block
        if (blk_fill > 56) begin
            for (int i = blk_fill; i < 64; i++) blk_bytes[i] = 8'h00;
            fold_block();
            blk_fill = 0;
        end
        for (int i = blk_fill; i < 56; i++) blk_bytes[i] = 8'h00;
        for (int i = 0; i < 8; i++) blk_bytes[56 + i] = bit_len[63 - 8*i -: 8];
        fold_block();

        for (int i = 0; i < 8; i++) begin
            dw.word = hash_state[i];
            dw.pos  = 3'(i);
            dw.last = (i == 7);
            digest_q = {digest_q, dw};
        end
        restart_hash();
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("tb_top: mismatch on %s at cycle %0d: got %0h, want %0h",
                 what, cycle_count, got, want);
        err_count++;
    endtask

    // every accepted digest request against the oldest expectation
    always @(posedge i_clk) begin
        t_digest_req want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (digest_q.size() == 0) begin
                report_mismatch("unexpected digest request", o_digest_word, 0);
            end else begin
                want = digest_q.pop_front();
                if (o_digest_word !== want.word)
                    report_mismatch("digest_word", o_digest_word, want.word);
                if (o_word_position !== want.pos)
                    report_mismatch("word_position", o_word_position, want.pos);
                if (o_final_word !== want.last)
                    report_mismatch("final_word", o_final_word, want.last);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // receiver back-pressure: phases of random length, each with its own pattern
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
        end
        stall_left--;
        case (stall_mode)
            0: i_stall <= 1'b0;                          // free running
            1: i_stall <= 1'($urandom_range(0, 1));      // coin toss
            2: i_stall <= ($urandom_range(0, 9) != 0);   // mostly stalled
            default: i_stall <= ((stall_left % 16) < 5); // periodic
        endcase
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // one request: bursts of random length with random gaps between them;
    // returns right after the accepting edge with i_valid still high
    task automatic send_request(logic [7:0] data, logic present, logic eom);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_valid          <= 1'b1;
        i_data_byte      <= data;
        i_byte_present   <= present;
        i_end_of_message <= eom;
        do @(posedge i_clk); while (o_stall);
        absorb_request(data, present, eom);
        if (present || eom) msg_items++;
    endtask

    // drop valid and hold off until every owed digest word has come
    task automatic wait_drained();
        i_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (digest_q.size() != 0);
    endtask

    // a message of random bytes, closed either on the last byte or by an
    // end-only request; empty requests are sprinkled in as noise
    task automatic send_message(int len, bit end_alone);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_request(8'($urandom_range(0, 255)), 1'b1, !end_alone && (i == len - 1));
        end
        if (end_alone || len == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // empty message, with and without an ignored data byte
    task automatic test_empty_message();
        send_request(8'h5a, 1'b0, 1'b0);
        send_request(8'hff, 1'b0, 1'b1);
        send_request(8'h00, 1'b0, 1'b1);
    endtask

    // byte extremes, the classic three-byte message, an empty request mid-message
    task automatic test_byte_extremes();
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'hff, 1'b1, 1'b1);
        send_request(8'h11, 1'b1, 1'b0);
        send_request(8'hee, 1'b0, 1'b0);
        send_request(8'h22, 1'b1, 1'b1);
    endtask

    // sender pauses until the dut has handed back every digest
    task automatic test_drain_pause();
        send_request(8'h80, 1'b1, 1'b0);
        send_request(8'h7f, 1'b1, 1'b1);
        wait_drained();
        send_request(8'h01, 1'b1, 1'b1);
        wait_drained();
    endtask

    // lengths around the padding limit and the block edge
    task automatic test_pad_boundaries();
        send_message(55, 1'($urandom_range(0, 1)));
        send_message(56, 1'($urandom_range(0, 1)));
        send_message(57, 1'($urandom_range(0, 1)));
        send_message(64, 1'($urandom_range(0, 1)));
    endtask

    // mostly short messages, some spanning one or two blocks
    task automatic test_random_messages(int first_item);
        int pick, len;
        while (msg_items - first_item < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                len = $urandom_range(0, 12);
            else if (pick < 9)
                len = $urandom_range(13, 63);
            else
                len = $urandom_range(64, 70);
            send_message(len, $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
    endtask

    initial begin
        int random_start;
        restart_hash();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_message();
        test_byte_extremes();
        test_drain_pause();
        test_pad_boundaries();
        random_start = msg_items;
        test_random_messages(random_start);

        // let the last digests drain, then give any stray output time to show
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
